// ----- sv/avba_pkg.sv -----
// Shared types, codes and defaults of the aligned vector block allocator.
package avba_pkg;

    // Default configuration
    localparam int VECTOR_COUNT_DEF = 256;
    localparam int RANGE_FIRST_DEF  = 32;
    localparam int RANGE_LAST_DEF   = 239;
    localparam int MAX_BLOCK_DEF    = 32;

    // Width of the base/bound arithmetic: vector plus count plus carry
    localparam int SUM_W = 11;

    // Request codes
    localparam logic [1:0] OP_ALLOC_ONE   = 2'd0;
    localparam logic [1:0] OP_ALLOC_BLOCK = 2'd1;
    localparam logic [1:0] OP_FREE_ONE    = 2'd2;
    localparam logic [1:0] OP_FREE_RANGE  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_CHECK = 5'b00100,
        S_MARK  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // Access to the in-use map
    typedef struct packed {
        logic       rd;
        logic       wr;
        logic       wdata;
        logic [7:0] addr;
    } t_map_req;

endpackage

// ----- sv/avba_map.sv -----
// In-use bitmap memory with per-entry valid bits; an unwritten entry reads as free.
module avba_map #(
    parameter int VECTOR_COUNT = avba_pkg::VECTOR_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  avba_pkg::t_map_req i_req,
    output logic               o_used
);
    import avba_pkg::*;

    localparam int AW = $clog2(VECTOR_COUNT);

    logic            r_mem [VECTOR_COUNT];
    logic [VECTOR_COUNT-1:0] r_vld;
    logic            r_rd_mem;
    logic            r_rd_vld;
    logic [AW-1:0]   w_addr;

    assign w_addr = i_req.addr[AW-1:0];

    // Write the bit store
    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[w_addr] <= i_req.wdata;
        end
    end

    // Mark entries as written; reset makes every entry read as its reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr) begin
            r_vld[w_addr] <= 1'b1;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_rd_mem <= r_mem[w_addr];
            r_rd_vld <= r_vld[w_addr];
        end
    end

    // Only entries inside the dynamic range are ever read; their reset value is free
    assign o_used = r_rd_vld & r_rd_mem;

endmodule

// ----- sv/aligned_vector_block_allocator.sv -----
// Top level of the aligned interrupt vector block allocator.
//
//  channel  direction  handshake                  payload
//  request  in         i_in_valid / o_in_stall    i_op, i_count, i_vector
//  result   out        o_out_valid / i_out_stall  o_status, o_granted
//
// Allocations probe one vector at a time through the single map port
// (read, then check), then mark the block vector by vector. Frees mark
// their run the same way without probing; rejected requests go straight to done.
// Reset clears the map valid bits together; there is no clearing pass.
// A result waits in the output register under i_out_stall while the next
// request is already accepted and served.
module aligned_vector_block_allocator #(
    parameter int VECTOR_COUNT = avba_pkg::VECTOR_COUNT_DEF,
    parameter int RANGE_FIRST  = avba_pkg::RANGE_FIRST_DEF,
    parameter int RANGE_LAST   = avba_pkg::RANGE_LAST_DEF,
    parameter int MAX_BLOCK    = avba_pkg::MAX_BLOCK_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_op,
    input  logic [8:0] i_count,
    input  logic [7:0] i_vector,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_granted
);
    import avba_pkg::*;

    localparam int TOP = (RANGE_LAST < VECTOR_COUNT - 1) ? RANGE_LAST : VECTOR_COUNT - 1;
    localparam bit RANGE_EMPTY = (RANGE_FIRST > TOP);
    localparam logic [SUM_W-1:0] LIMIT   = SUM_W'(TOP + 1);
    localparam logic [SUM_W-1:0] FIRST_W = SUM_W'(RANGE_FIRST);
    localparam logic [8:0]       MAX_W   = 9'(MAX_BLOCK);

    t_state           r_state, n_state;
    logic [SUM_W-1:0] r_base,  n_base;
    logic [8:0]       r_len,   n_len;
    logic [7:0]       r_k,     n_k;
    logic             r_wbit,  n_wbit;
    logic [1:0]       r_res_status,  n_res_status;
    logic [7:0]       r_res_granted, n_res_granted;
    logic             r_out_valid;
    logic [1:0]       r_status;
    logic [7:0]       r_granted;

    t_map_req         w_req;
    logic             w_used;
    logic             w_accept;
    logic             w_load;
    logic             w_last;
    logic [SUM_W-1:0] w_addr_sum;
    logic [SUM_W-1:0] w_cnt;
    logic [SUM_W-1:0] w_vec;
    logic [SUM_W-1:0] w_alen;
    logic [SUM_W-1:0] w_abase;
    logic [SUM_W-1:0] w_len;
    logic [SUM_W-1:0] w_next_base;
    logic [8:0]       w_alloc_len;
    logic             w_bad_block;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = (r_state != S_IDLE);

    // Request decode: allocate one is a block of one, free one a run of one
    assign w_cnt       = {2'b00, i_count};
    assign w_vec       = {3'b000, i_vector};
    assign w_alloc_len = (i_op == OP_ALLOC_ONE) ? 9'd1 : i_count;
    assign w_alen      = {2'b00, w_alloc_len};
    assign w_bad_block = (i_count == 9'd0) || ((i_count & (i_count - 9'd1)) != 9'd0) ||
                         (i_count > MAX_W);
    assign w_abase     = (FIRST_W + w_alen - SUM_W'(1)) & ~(w_alen - SUM_W'(1));

    // Walk position in the current run
    assign w_len       = {2'b00, r_len};
    assign w_addr_sum  = r_base + {3'b000, r_k};
    assign w_last      = ({1'b0, r_k} == (r_len - 9'd1));
    assign w_next_base = r_base + w_len;

    // Map port
    always_comb begin
        w_req.rd    = (r_state == S_READ);
        w_req.wr    = (r_state == S_MARK);
        w_req.wdata = r_wbit;
        w_req.addr  = w_addr_sum[7:0];
    end

    avba_map #(
        .VECTOR_COUNT (VECTOR_COUNT)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_used  (w_used)
    );

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_base        = r_base;
        n_len         = r_len;
        n_k           = r_k;
        n_wbit        = r_wbit;
        n_res_status  = r_res_status;
        n_res_granted = r_res_granted;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_k           = 8'd0;
                    n_res_status  = ST_OK;
                    n_res_granted = 8'd0;
                    n_state       = S_DONE;
                    if (i_op == OP_ALLOC_ONE || i_op == OP_ALLOC_BLOCK) begin
                        n_len  = w_alloc_len;
                        n_base = w_abase;
                        n_wbit = 1'b1;
                        if (i_op == OP_ALLOC_BLOCK && w_bad_block) begin
                            n_res_status = ST_INVALID;
                        end else if (RANGE_EMPTY || (w_abase + w_alen > LIMIT)) begin
                            n_res_status = ST_EXHAUSTED;
                        end else begin
                            n_state = S_READ;
                        end
                    end else begin
                        n_len  = (i_op == OP_FREE_ONE) ? 9'd1 : i_count;
                        n_base = w_vec;
                        n_wbit = 1'b0;
                        if (RANGE_EMPTY || (i_op == OP_FREE_RANGE && i_count == 9'd0) ||
                            (w_vec < FIRST_W) ||
                            (w_vec + ((i_op == OP_FREE_ONE) ? SUM_W'(1) : w_cnt) > LIMIT)) begin
                            n_res_status = ST_INVALID;
                        end else begin
                            n_state = S_MARK;
                        end
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_used) begin
                    // Skip to the next aligned candidate or give up
                    n_k = 8'd0;
                    if (w_next_base + w_len > LIMIT) begin
                        n_res_status = ST_EXHAUSTED;
                        n_state      = S_DONE;
                    end else begin
                        n_base  = w_next_base;
                        n_state = S_READ;
                    end
                end else if (w_last) begin
                    n_k           = 8'd0;
                    n_res_granted = r_base[7:0];
                    n_state       = S_MARK;
                end else begin
                    n_k     = r_k + 8'd1;
                    n_state = S_READ;
                end
            end
            S_MARK: begin
                if (w_last) begin
                    n_state = S_DONE;
                end else begin
                    n_k = r_k + 8'd1;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold walk and pending result payload
    always_ff @(posedge i_clk) begin
        r_base        <= n_base;
        r_len         <= n_len;
        r_k           <= n_k;
        r_wbit        <= n_wbit;
        r_res_status  <= n_res_status;
        r_res_granted <= n_res_granted;
    end

    // Output register: load a finished result, drop it once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status  <= r_res_status;
            r_granted <= r_res_granted;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_granted   = r_granted;

    // A failed or rejected request never reports a grant
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_granted == 8'd0))
        else $error("nonzero grant on failed request");

    // A check always follows the read that fetched its bit
    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> ($past(r_state) == S_READ))
        else $error("check without preceding map read");

    // Walk offset stays inside the run while marking
    a_mark_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> ({1'b0, r_k} < r_len))
        else $error("mark offset beyond run");

endmodule

// ----- test/avba_result_checker.sv -----
// Result checker for the aligned vector block allocator: tracks the in-use map and compares.
`timescale 1ns / 1ps

module avba_result_checker #(
    parameter int VECTOR_COUNT = avba_pkg::VECTOR_COUNT_DEF,
    parameter int RANGE_FIRST  = avba_pkg::RANGE_FIRST_DEF,
    parameter int RANGE_LAST   = avba_pkg::RANGE_LAST_DEF,
    parameter int MAX_BLOCK    = avba_pkg::MAX_BLOCK_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_op,
    input  logic [8:0] i_count,
    input  logic [7:0] i_vector,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [1:0] i_status,
    input  logic [7:0] i_granted,
    output int         o_fail_count,
    output int         o_pending
);
    import avba_pkg::*;

    // Clip the top of the dynamic range to the vector count
    localparam int CAP      = (VECTOR_COUNT - 1 > 255) ? 255 : VECTOR_COUNT - 1;
    localparam int TOP      = (RANGE_LAST < CAP) ? RANGE_LAST : CAP;
    localparam bit NO_RANGE = RANGE_FIRST > TOP;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] granted;
    } t_grant;

    logic [255:0] busy_map;
    t_grant       grants_due[$];
    int           mismatches = 0;

    assign o_fail_count = mismatches;

    // Print one line for a failure and count it
    task automatic report_error(input string msg);
        $display("%0t ns: error: %s", $time, msg);
        mismatches++;
    endtask

    // Serve one request against the shadow map and return its result
    function automatic t_grant serve_request(input logic [1:0] op, input logic [8:0] count,
                                             input logic [7:0] vector);
        t_grant res;
        int     base;
        int     len;
        int     k;
        bit     all_free;
        res.status  = ST_OK;
        res.granted = '0;
        len = count;
        case (op)
            OP_ALLOC_ONE: begin
                res.status = ST_EXHAUSTED;
                if (!NO_RANGE) begin
                    for (base = RANGE_FIRST; base <= TOP; base++) begin
                        if (!busy_map[base]) begin
                            busy_map[base] = 1'b1;
                            res.status     = ST_OK;
                            res.granted    = base[7:0];
                            break;
                        end
                    end
                end
            end
            OP_ALLOC_BLOCK: begin
                if (len == 0 || (len & (len - 1)) != 0 || len > MAX_BLOCK) begin
                    res.status = ST_INVALID;
                end else begin
                    res.status = ST_EXHAUSTED;
                    if (!NO_RANGE) begin
                        // Walk aligned bases from the first one inside the range
                        for (base = ((RANGE_FIRST + len - 1) / len) * len;
                             base + len - 1 <= TOP; base += len) begin
                            all_free = 1'b1;
                            for (k = 0; k < len; k++)
                                if (busy_map[base + k]) all_free = 1'b0;
                            if (all_free) begin
                                for (k = 0; k < len; k++) busy_map[base + k] = 1'b1;
                                res.status  = ST_OK;
                                res.granted = base[7:0];
                                break;
                            end
                        end
                    end
                end
            end
            OP_FREE_ONE: begin
                if (NO_RANGE || vector < RANGE_FIRST || vector > TOP)
                    res.status = ST_INVALID;
                else
                    busy_map[vector] = 1'b0;
            end
            default: begin
                if (NO_RANGE || len == 0 || vector < RANGE_FIRST ||
                    int'(vector) + len - 1 > TOP) begin
                    res.status = ST_INVALID;
                end else begin
                    for (k = 0; k < len; k++) busy_map[int'(vector) + k] = 1'b0;
                end
            end
        endcase
        return res;
    endfunction

    // Watch both channels: compare each result transfer, predict each request transfer
    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            for (int i = 0; i < 256; i++)
                busy_map[i] = !(i >= RANGE_FIRST && i <= TOP);
            grants_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (grants_due.size() == 0) begin
                    report_error($sformatf("result with none pending: status %0d granted %0d",
                                           i_status, i_granted));
                end else begin
                    want = grants_due.pop_front();
                    if (i_status !== want.status)
                        report_error($sformatf("status expected %0d got %0d",
                                               want.status, i_status));
                    if (i_granted !== want.granted)
                        report_error($sformatf("granted expected %0d got %0d",
                                               want.granted, i_granted));
                end
            end
            if (i_in_valid && !i_in_stall)
                grants_due.push_back(serve_request(i_op, i_count, i_vector));
        end
        o_pending <= grants_due.size();
    end

endmodule

// ----- test/aligned_vector_block_allocator_tb.sv -----
// Testbench top for the aligned vector block allocator: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module aligned_vector_block_allocator_tb;
    import avba_pkg::*;

    localparam int LO           = RANGE_FIRST_DEF;
    localparam int HI           = RANGE_LAST_DEF;
    localparam int RANDOM_ITEMS = 1225;
    localparam int HOLD_CYCLES  = 3000;
    localparam int HOLD_AFTER   = 150;
    localparam int DRAIN_CYCLES = 600;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_op;
    logic [8:0] i_count;
    logic [7:0] i_vector;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [1:0] o_status;
    logic [7:0] o_granted;
    int         fail_count;
    int         pending;
    int         send_calm = 0;

    aligned_vector_block_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_count     (i_count),
        .i_vector    (i_vector),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_granted   (o_granted)
    );

    avba_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_count      (i_count),
        .i_vector     (i_vector),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_status     (o_status),
        .i_granted    (o_granted),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Generate a 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Offer one request after a random gap and hold it until the transfer
    task automatic offer_request(input logic [1:0] op, input int count, input int vector);
        int gap;
        if (send_calm > 0) begin
            send_calm--;
            gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            send_calm = $urandom_range(20, 60);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_count    <= count[8:0];
        i_vector   <= vector[7:0];
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Drive the result side: random stalls, calm stretches, one long hold-off
    initial begin : result_sink
        int gap;
        int taken;
        int calm;
        bit held;
        taken = 0;
        calm  = 0;
        held  = 1'b0;
        i_out_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!held && taken >= HOLD_AFTER) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end else if (calm > 0) begin
                calm--;
                gap = 0;
            end else if ($urandom_range(0, 15) == 0) begin
                calm = $urandom_range(20, 60);
                gap  = 0;
            end else begin
                gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
            end
            if (gap != 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
            taken++;
        end
    end

    // Reset, directed requests, random bursts, then the verdict
    initial begin : request_source
        logic [1:0] op;
        int         count;
        int         vector;
        int         kind;
        int         burst;
        int         issued;
        bit         paused;
        issued = 0;
        paused = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_op       <= OP_ALLOC_ONE;
        i_count    <= '0;
        i_vector   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Allocate one with its ignored fields all ones, then small aligned blocks
        offer_request(OP_ALLOC_ONE, 9'h1FF, 8'hFF);
        offer_request(OP_ALLOC_BLOCK, 1, 0);
        offer_request(OP_ALLOC_BLOCK, 2, 0);
        offer_request(OP_ALLOC_BLOCK, 4, 0);
        offer_request(OP_ALLOC_BLOCK, 8, 0);
        // Reject block sizes that are zero, not a power of two, or too large
        offer_request(OP_ALLOC_BLOCK, 0, 0);
        offer_request(OP_ALLOC_BLOCK, 3, 0);
        offer_request(OP_ALLOC_BLOCK, 64, 0);
        offer_request(OP_ALLOC_BLOCK, 9'h1FF, 0);
        // Reject single frees outside the range, accept one inside
        offer_request(OP_FREE_ONE, 0, 0);
        offer_request(OP_FREE_ONE, 0, 255);
        offer_request(OP_FREE_ONE, 0, HI + 1);
        offer_request(OP_FREE_ONE, 0, LO);
        // Reject bad free runs: empty, base below range, run past range, huge
        offer_request(OP_FREE_RANGE, 0, LO);
        offer_request(OP_FREE_RANGE, 1, LO - 1);
        offer_request(OP_FREE_RANGE, 2, HI);
        offer_request(OP_FREE_RANGE, 256, 255);
        // Fill the range with big blocks until a block search fails, then smaller blocks and one single
        repeat (6) offer_request(OP_ALLOC_BLOCK, 32, 0);
        offer_request(OP_ALLOC_BLOCK, 16, 0);
        offer_request(OP_ALLOC_BLOCK, 16, 0);
        offer_request(OP_ALLOC_ONE, 0, 0);
        // Free the whole range
        offer_request(OP_FREE_RANGE, HI - LO + 1, LO);

        // Random bursts: allocations, frees, malformed requests and noise
        while (issued < RANDOM_ITEMS) begin
            kind  = $urandom_range(0, 9);
            burst = $urandom_range(4, 40);
            for (int k = 0; k < burst; k++) begin
                if (kind < 4) begin
                    op     = $urandom_range(0, 1) ? OP_ALLOC_ONE : OP_ALLOC_BLOCK;
                    count  = (op == OP_ALLOC_BLOCK) ? (1 << $urandom_range(0, 5))
                                                    : $urandom_range(0, 511);
                    vector = $urandom_range(0, 255);
                end else if (kind < 7) begin
                    vector = $urandom_range(LO, HI);
                    if ($urandom_range(0, 2) != 0) begin
                        op    = OP_FREE_ONE;
                        count = $urandom_range(0, 511);
                    end else if ($urandom_range(0, 15) == 0) begin
                        op     = OP_FREE_RANGE;
                        vector = LO;
                        count  = HI - LO + 1;
                    end else begin
                        op    = OP_FREE_RANGE;
                        count = $urandom_range(1, 48);
                    end
                end else if (kind == 7) begin
                    op     = $urandom_range(0, 1) ? OP_ALLOC_BLOCK : OP_FREE_RANGE;
                    count  = $urandom_range(0, 511);
                    vector = $urandom_range(0, 255);
                end else begin
                    op     = 2'($urandom_range(0, 3));
                    count  = $urandom_range(0, 511);
                    vector = $urandom_range(0, 255);
                end
                offer_request(op, count, vector);
            end
            issued += burst;
            // Pause once midway until the block has answered everything
            if (!paused && issued >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                wait_for_results();
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #60_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
